[sv/cfc_pkg.sv]
package cfc_pkg;

   localparam int CURVE_POINTS    = 4;
   localparam int BYTES_PER_POINT = 4;
   localparam int NUM_IDS         = 7;
   localparam int NUM_WORDS       = 8;
   localparam int STORE_BYTES     = 2 * NUM_WORDS;
   localparam int STORE_AW        = $clog2(STORE_BYTES);

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  COUNT_MAX     = 8'hFF;
   localparam logic [7:0]  MIN_FRAME_LEN = 8'd4;
   // frame bytes that are not payload: header, id, two trailer bytes
   localparam logic [7:0]  OVERHEAD_LEN  = 8'd4;
   localparam logic [7:0]  PAYLOAD_START = 8'd2;
   localparam logic [7:0]  STORE_END     = 8'(STORE_BYTES + 2);

   localparam logic [7:0] LEN_SET_TARGET   = 8'd2;
   localparam logic [7:0] LEN_SET_PID      = 8'd6;
   localparam logic [7:0] LEN_SET_FAN_CURVE = 8'(BYTES_PER_POINT * CURVE_POINTS);
   localparam logic [7:0] LEN_CLEAR_ALARM  = 8'd0;
   localparam logic [7:0] LEN_SET_COOLING  = 8'd1;
   localparam logic [7:0] LEN_SET_OVERTEMP = 8'd2;
   localparam logic [7:0] LEN_SET_FAN_LOOP = 8'd1;

   typedef enum logic [2:0] {
      REG_FRAME_HEADER     = 3'd0,
      REG_ID_SET_TARGET    = 3'd1,
      REG_ID_SET_PID       = 3'd2,
      REG_ID_SET_FAN_CURVE = 3'd3,
      REG_ID_CLEAR_ALARM   = 3'd4,
      REG_ID_SET_COOLING   = 3'd5,
      REG_ID_SET_OVERTEMP  = 3'd6,
      REG_ID_SET_FAN_LOOP  = 3'd7
   } csr_addr_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_FRAME = 2'd1,
      STATUS_UNKNOWN   = 2'd2,
      STATUS_BAD_LEN   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_NONE          = 3'd0,
      KIND_SET_TARGET    = 3'd1,
      KIND_SET_PID       = 3'd2,
      KIND_SET_FAN_CURVE = 3'd3,
      KIND_CLEAR_ALARM   = 3'd4,
      KIND_SET_COOLING   = 3'd5,
      KIND_SET_OVERTEMP  = 3'd6,
      KIND_SET_FAN_LOOP  = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0]                 frame_header;
      logic [NUM_IDS-1:0][7:0]    ids;
   } cfg_type;

   // frame state as it stands after the last byte of a frame
   typedef struct packed {
      logic        valid;
      logic [7:0]  count;
      logic        header_ok;
      logic [15:0] crc;
      logic [15:0] trailer;
      logic [7:0]  cmd_id;
   } frame_end_type;

   // one byte of CRC-16/MODBUS, reflected
   function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] expected_len(cmd_kind_type kind);
      logic [7:0] len;
      unique case (kind)
         KIND_SET_TARGET:    len = LEN_SET_TARGET;
         KIND_SET_PID:       len = LEN_SET_PID;
         KIND_SET_FAN_CURVE: len = LEN_SET_FAN_CURVE;
         KIND_CLEAR_ALARM:   len = LEN_CLEAR_ALARM;
         KIND_SET_COOLING:   len = LEN_SET_COOLING;
         KIND_SET_OVERTEMP:  len = LEN_SET_OVERTEMP;
         KIND_SET_FAN_LOOP:  len = LEN_SET_FAN_LOOP;
         KIND_NONE:          len = LEN_SET_FAN_LOOP;
      endcase
      return len;
   endfunction

endpackage

[sv/cfc_req_if.sv]
interface cfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_frame;

   modport source (output valid, output rx_byte, output end_of_frame, input ready);
   modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

[sv/cfc_rsp_if.sv]
interface cfc_rsp_if;
   import cfc_pkg::*;
   logic         valid;
   logic         ready;
   status_type   status;
   logic [7:0]   command_id;
   cmd_kind_type command_kind;
   logic [15:0]  word0;
   logic [15:0]  word1;
   logic [15:0]  word2;
   logic [15:0]  word3;
   logic [15:0]  word4;
   logic [15:0]  word5;
   logic [15:0]  word6;
   logic [15:0]  word7;

   modport source (output valid, output status, output command_id, output command_kind,
                   output word0, output word1, output word2, output word3,
                   output word4, output word5, output word6, output word7,
                   input ready);
   modport sink   (input valid, input status, input command_id, input command_kind,
                   input word0, input word1, input word2, input word3,
                   input word4, input word5, input word6, input word7,
                   output ready);
endinterface

[sv/cfc_csr_if.sv]
interface cfc_csr_if;
   import cfc_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   logic [7:0]   data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

[sv/cfc_csr_regs.sv]
module cfc_csr_regs (
   input  logic             clock,
   input  logic             reset,
   cfc_csr_if.sink          csr_ch,
   output cfc_pkg::cfg_type cfg
);
   import cfc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_header <= 8'h00;
         for (int i = 0; i < NUM_IDS; i++) begin
            cfg_ff.ids[i] <= 8'(i + 1);
         end
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            REG_FRAME_HEADER:     cfg_ff.frame_header <= csr_ch.data;
            REG_ID_SET_TARGET:    cfg_ff.ids[0] <= csr_ch.data;
            REG_ID_SET_PID:       cfg_ff.ids[1] <= csr_ch.data;
            REG_ID_SET_FAN_CURVE: cfg_ff.ids[2] <= csr_ch.data;
            REG_ID_CLEAR_ALARM:   cfg_ff.ids[3] <= csr_ch.data;
            REG_ID_SET_COOLING:   cfg_ff.ids[4] <= csr_ch.data;
            REG_ID_SET_OVERTEMP:  cfg_ff.ids[5] <= csr_ch.data;
            REG_ID_SET_FAN_LOOP:  cfg_ff.ids[6] <= csr_ch.data;
         endcase
      end
   end

endmodule

[sv/cfc_frame_track.sv]
module cfc_frame_track (
   input  logic                                    clock,
   input  logic                                    reset,
   cfc_req_if.sink                                 req_ch,
   input  cfc_pkg::cfg_type                        cfg,
   input  logic                                    out_busy,
   output cfc_pkg::frame_end_type                  frame_end,
   output logic [cfc_pkg::STORE_BYTES-1:0][7:0]    store
);
   import cfc_pkg::*;

   logic        stage_valid_ff, stage_valid_in;
   logic [7:0]  stage_byte_ff;
   logic        stage_last_ff;

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  delay_ff, delay_in;
   logic [7:0]  older_ff, older_in;
   logic        header_ff, header_in;
   logic [7:0]  cmd_id_ff, cmd_id_in;
   logic [STORE_BYTES-1:0][7:0] store_ff;

   logic        move;
   logic        accept;
   logic        store_we;
   logic [STORE_AW-1:0] store_idx;
   logic [15:0] crc_upd;
   logic [7:0]  count_upd;
   logic        header_upd;
   logic [7:0]  cmd_id_upd;

   // a frame-ending byte waits here while the result register is still full
   assign move         = stage_valid_ff && !(stage_last_ff && out_busy);
   assign req_ch.ready = !stage_valid_ff || move;
   assign accept       = req_ch.valid && req_ch.ready;
   assign stage_valid_in = accept || (stage_valid_ff && !move);
   assign store        = store_ff;

   always_comb begin
      crc_upd    = (count_ff >= PAYLOAD_START) ? crc_fold(crc_ff, older_ff) : crc_ff;
      header_upd = (count_ff == 8'd0) ? (stage_byte_ff == cfg.frame_header) : header_ff;
      cmd_id_upd = (count_ff == 8'd1) ? stage_byte_ff : cmd_id_ff;
      count_upd  = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 8'd1;
      store_we   = move && (count_ff >= PAYLOAD_START) && (count_ff < STORE_END);
      store_idx  = STORE_AW'(count_ff - PAYLOAD_START);

      crc_in    = crc_ff;
      count_in  = count_ff;
      delay_in  = delay_ff;
      older_in  = older_ff;
      header_in = header_ff;
      cmd_id_in = cmd_id_ff;
      if (move) begin
         if (stage_last_ff) begin
            crc_in    = CRC_INIT;
            count_in  = 8'd0;
            delay_in  = 8'd0;
            older_in  = 8'd0;
            header_in = 1'b0;
            cmd_id_in = 8'd0;
         end else begin
            crc_in    = crc_upd;
            count_in  = count_upd;
            delay_in  = stage_byte_ff;
            older_in  = delay_ff;
            header_in = header_upd;
            cmd_id_in = cmd_id_upd;
         end
      end

      frame_end.valid     = move && stage_last_ff;
      frame_end.count     = count_upd;
      frame_end.header_ok = header_upd;
      frame_end.crc       = crc_upd;
      frame_end.trailer   = {stage_byte_ff, delay_ff};
      frame_end.cmd_id    = cmd_id_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         crc_ff         <= CRC_INIT;
         count_ff       <= 8'd0;
         delay_ff       <= 8'd0;
         older_ff       <= 8'd0;
         header_ff      <= 1'b0;
         cmd_id_ff      <= 8'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         crc_ff         <= crc_in;
         count_ff       <= count_in;
         delay_ff       <= delay_in;
         older_ff       <= older_in;
         header_ff      <= header_in;
         cmd_id_ff      <= cmd_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_byte_ff <= req_ch.rx_byte;
         stage_last_ff <= req_ch.end_of_frame;
      end
      if (store_we) begin
         store_ff[store_idx] <= stage_byte_ff;
      end
   end

endmodule

[sv/cfc_result.sv]
module cfc_result (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cfc_pkg::cfg_type                        cfg,
   input  cfc_pkg::frame_end_type                  frame_end,
   input  logic [cfc_pkg::STORE_BYTES-1:0][7:0]    store,
   output logic                                    out_busy,
   cfc_rsp_if.source                               rsp_ch
);
   import cfc_pkg::*;

   logic         valid_ff, valid_in;
   status_type   status_ff, status_in;
   logic [7:0]   cmd_id_ff;
   cmd_kind_type kind_ff, kind_in;
   logic [NUM_WORDS-1:0][15:0] words_ff, words_in;
   logic [7:0]   plen;
   logic [STORE_BYTES-1:0][7:0] masked;

   assign out_busy = valid_ff && !rsp_ch.ready;
   assign valid_in = frame_end.valid || out_busy;

   always_comb begin
      kind_in = KIND_NONE;
      if (frame_end.count >= PAYLOAD_START) begin
         // walk down so the lowest matching register wins
         for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (cfg.ids[i] == frame_end.cmd_id) begin
               kind_in = cmd_kind_type'(3'(i + 1));
            end
         end
      end

      plen = frame_end.count - OVERHEAD_LEN;
      if (frame_end.count < MIN_FRAME_LEN || !frame_end.header_ok ||
          frame_end.crc != frame_end.trailer) begin
         status_in = STATUS_BAD_FRAME;
      end else if (kind_in == KIND_NONE) begin
         status_in = STATUS_UNKNOWN;
      end else if (plen == expected_len(kind_in)) begin
         status_in = STATUS_OK;
      end else begin
         status_in = STATUS_BAD_LEN;
      end

      for (int i = 0; i < STORE_BYTES; i++) begin
         masked[i] = (status_in == STATUS_OK && 8'(i) < plen) ? store[i] : 8'h00;
      end
      for (int j = 0; j < NUM_WORDS; j++) begin
         words_in[j] = {masked[2*j+1], masked[2*j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end.valid) begin
         status_ff <= status_in;
         cmd_id_ff <= frame_end.cmd_id;
         kind_ff   <= kind_in;
         words_ff  <= words_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.command_id   = cmd_id_ff;
   assign rsp_ch.command_kind = kind_ff;
   assign rsp_ch.word0        = words_ff[0];
   assign rsp_ch.word1        = words_ff[1];
   assign rsp_ch.word2        = words_ff[2];
   assign rsp_ch.word3        = words_ff[3];
   assign rsp_ch.word4        = words_ff[4];
   assign rsp_ch.word5        = words_ff[5];
   assign rsp_ch.word6        = words_ff[6];
   assign rsp_ch.word7        = words_ff[7];

endmodule

[sv/command_frame_checker_core.sv]
// Channel   Direction  Transfer carries
// req_ch    in         rx_byte, end_of_frame
// rsp_ch    out        status, command_id, command_kind, word0..word7
// csr_ch    in         addr (register index), data
//
// One byte per cycle. A byte passes through the input stage; the last byte of
// a frame loads the result register on its way out of that stage. The per-byte
// CRC update is one unrolled 8-bit step. Reset clears all frame state and loads
// the default ids; no clearing pass. A frame-ending byte holds in the input
// stage while an earlier result has not been taken; other bytes pass regardless.
module command_frame_checker_core (
   input  logic        clock,
   input  logic        reset,
   cfc_req_if.sink     req_ch,
   cfc_rsp_if.source   rsp_ch,
   cfc_csr_if.sink     csr_ch
);
   import cfc_pkg::*;

   cfg_type                     cfg;
   frame_end_type               frame_end;
   logic [STORE_BYTES-1:0][7:0] store;
   logic                        out_busy;

   cfc_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   cfc_frame_track u_track (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .out_busy  (out_busy),
      .frame_end (frame_end),
      .store     (store)
   );

   cfc_result u_result (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .frame_end (frame_end),
      .store     (store),
      .out_busy  (out_busy),
      .rsp_ch    (rsp_ch)
   );

   // a finished frame never lands on a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(frame_end.valid && out_busy))
      else $error("frame result overwrote a pending result");

   a_ok_has_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_OK) |-> rsp_ch.command_kind != KIND_NONE)
      else $error("ok status without a matched command");

   a_bad_zero_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |->
         (rsp_ch.word0 == 16'h0 && rsp_ch.word1 == 16'h0 && rsp_ch.word2 == 16'h0 &&
          rsp_ch.word3 == 16'h0 && rsp_ch.word4 == 16'h0 && rsp_ch.word5 == 16'h0 &&
          rsp_ch.word6 == 16'h0 && rsp_ch.word7 == 16'h0))
      else $error("payload words set on a failed frame");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

[test/tb_top.sv]
module tb_top;
   import cfc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_BYTES  = 170;
   localparam int NUM_PHASES   = 6;
   localparam int HOLD_CYCLES  = 400;

   typedef logic [7:0] byte_q_t[$];

   typedef struct packed {
      status_type        status;
      logic [7:0]        command_id;
      cmd_kind_type      kind;
      logic [7:0][15:0]  word;
   } cmd_result_t;

   // per-frame note: a directed frame may carry its result typed in by hand
   typedef struct {
      bit          typed;
      cmd_result_t res;
   } frame_note_t;

   typedef struct {
      int           len;     // 0: whole frame, else cut to this many bytes
      logic [7:0]   hdr;
      logic [7:0]   id;
      int           plen;
      logic [7:0]   fill;
      logic [15:0]  crc_flip;
      bit           typed;
      status_type   st;
      cmd_kind_type kd;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfc_req_if req_ch();
   cfc_rsp_if rsp_ch();
   cfc_csr_if csr_ch();

   command_frame_checker_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // shadow of the configuration registers
   logic [7:0] cfg_header;
   logic [7:0] cfg_ids [NUM_IDS];

   // shadow of the per-frame state
   logic [15:0] crc_acc;
   logic [7:0]  byte_cnt;
   logic [7:0]  trail_new;
   logic [7:0]  trail_old;
   logic        hdr_seen_ok;
   logic [7:0]  cmd_seen;
   logic [7:0]  pay_store [STORE_BYTES];

   cmd_result_t result_fifo[$];
   frame_note_t frame_notes[$];
   bit          failed;
   int          stall_cycles;
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          rsp_hold;

   // reset config: header 0, ids 1..7
   dir_row_t dir_rows [9] = '{
      '{1, 8'h00, 8'h00, 0, 8'h00, 16'h0000, 1'b1, STATUS_BAD_FRAME, KIND_NONE},
      '{2, 8'h00, 8'h04, 0, 8'h00, 16'h0000, 1'b1, STATUS_BAD_FRAME, KIND_CLEAR_ALARM},
      '{3, 8'hFF, 8'hFF, 1, 8'hFF, 16'h0000, 1'b1, STATUS_BAD_FRAME, KIND_NONE},
      '{0, 8'h00, 8'h04, 0, 8'h00, 16'h0000, 1'b0, STATUS_OK,        KIND_CLEAR_ALARM},
      '{0, 8'h5A, 8'h04, 0, 8'h00, 16'h0000, 1'b1, STATUS_BAD_FRAME, KIND_CLEAR_ALARM},
      '{0, 8'h00, 8'h05, 1, 8'h80, 16'h0100, 1'b1, STATUS_BAD_FRAME, KIND_SET_COOLING},
      '{0, 8'h00, 8'hFF, 0, 8'h00, 16'h0000, 1'b1, STATUS_UNKNOWN,   KIND_NONE},
      '{0, 8'h00, 8'h01, 1, 8'hAA, 16'h0000, 1'b1, STATUS_BAD_LEN,   KIND_SET_TARGET},
      '{0, 8'h00, 8'h07, 1, 8'hFF, 16'h0000, 1'b0, STATUS_OK,        KIND_SET_FAN_LOOP}
   };

   function automatic logic [15:0] modbus_crc_byte(logic [15:0] acc, logic [7:0] d);
      logic [15:0] v;
      v = acc ^ {8'h00, d};
      repeat (8) v = (v >> 1) ^ (v[0] ? CRC_POLY : 16'h0000);
      return v;
   endfunction

   function automatic int payload_len(cmd_kind_type k);
      case (k)
         KIND_SET_TARGET, KIND_SET_OVERTEMP: return 2;
         KIND_SET_PID:                       return 6;
         KIND_SET_FAN_CURVE:                 return 4 * CURVE_POINTS;
         KIND_CLEAR_ALARM:                   return 0;
         default:                            return 1;
      endcase
   endfunction

   function automatic void clear_frame_state();
      crc_acc     = CRC_INIT;
      byte_cnt    = 8'h00;
      trail_new   = 8'h00;
      trail_old   = 8'h00;
      hdr_seen_ok = 1'b0;
      cmd_seen    = 8'h00;
   endfunction

   // advance the shadow state by one byte; returns 1 when a result is due
   function automatic bit predict_frame_byte(input logic [7:0] b, input bit last,
                                             output cmd_result_t r);
      int          n;
      int          plen;
      int          lo;
      logic [15:0] trailer;
      r = '0;
      n = byte_cnt;
      // a byte enters the CRC only once two newer bytes prove it is not trailer
      if (n >= 2) crc_acc = modbus_crc_byte(crc_acc, trail_old);
      trail_old = trail_new;
      trail_new = b;
      if (n == 0) hdr_seen_ok = (b == cfg_header);
      else if (n == 1) cmd_seen = b;
      else if (n - 2 < STORE_BYTES) pay_store[n - 2] = b;
      if (n < 255) n++;
      byte_cnt = 8'(n);
      if (!last) return 1'b0;

      r.kind = KIND_NONE;
      if (n >= 2) begin
         r.command_id = cmd_seen;
         // lowest register wins on duplicates
         for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (cfg_ids[i] == cmd_seen) r.kind = cmd_kind_type'(i + 1);
         end
      end
      trailer = {trail_new, trail_old};
      plen = n - 4;
      if (n < 4 || !hdr_seen_ok || crc_acc != trailer) begin
         r.status = STATUS_BAD_FRAME;
      end else if (r.kind == KIND_NONE) begin
         r.status = STATUS_UNKNOWN;
      end else if (plen != payload_len(r.kind)) begin
         r.status = STATUS_BAD_LEN;
      end else begin
         r.status = STATUS_OK;
         for (int j = 0; j < NUM_WORDS; j++) begin
            lo = 2 * j;
            r.word[j][7:0]  = (lo < plen)     ? pay_store[lo]     : 8'h00;
            r.word[j][15:8] = (lo + 1 < plen) ? pay_store[lo + 1] : 8'h00;
         end
      end
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic void check_result(cmd_result_t got);
      cmd_result_t want;
      want = result_fifo.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         failed = 1'b1;
      end
      if (got.command_id !== want.command_id) begin
         $error("command_id: expected %0d, got %0d", want.command_id, got.command_id);
         failed = 1'b1;
      end
      if (got.kind !== want.kind) begin
         $error("command_kind: expected %0d, got %0d", want.kind, got.kind);
         failed = 1'b1;
      end
      for (int j = 0; j < NUM_WORDS; j++) begin
         if (got.word[j] !== want.word[j]) begin
            $error("word%0d: expected %0d, got %0d", j, want.word[j], got.word[j]);
            failed = 1'b1;
         end
      end
   endfunction

   function automatic void build_frame(output byte_q_t q, input logic [7:0] hdr,
                                       input logic [7:0] id, input byte_q_t pay,
                                       input logic [15:0] flip);
      logic [15:0] c;
      q = {hdr, id};
      foreach (pay[i]) q.push_back(pay[i]);
      c = CRC_INIT;
      foreach (q[i]) c = modbus_crc_byte(c, q[i]);
      c = c ^ flip;
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
   endfunction

   task automatic make_random_frame(output byte_q_t q, input bit long_frame);
      int          r;
      int          plen;
      int          kidx;
      logic [7:0]  hdr;
      logic [7:0]  id;
      logic [15:0] flip;
      byte_q_t     pay;
      r    = $urandom_range(99);
      hdr  = cfg_header;
      flip = 16'h0000;
      kidx = $urandom_range(NUM_IDS - 1);
      id   = cfg_ids[kidx];
      plen = payload_len(cmd_kind_type'(kidx + 1));
      if (long_frame || $urandom_range(199) == 0) begin
         // runs the byte count up to or into saturation
         plen = $urandom_range(262, 250);
      end else if (r >= 70 && r < 80) begin
         plen = $urandom_range(20);
         if ($urandom_range(1)) id = 8'($urandom);
      end else if (r >= 80 && r < 90) begin
         plen = $urandom_range(8);
         if ($urandom_range(1)) hdr = 8'($urandom);
         else flip = 16'($urandom_range(65535, 1));
         if ($urandom_range(1)) id = 8'($urandom);
      end
      pay = {};
      for (int i = 0; i < plen; i++) pay.push_back(8'($urandom));
      build_frame(q, hdr, id, pay, flip);
      if (r >= 90 && !long_frame) begin
         // raw noise, no structure at all
         q = {};
         repeat ($urandom_range(6, 1)) q.push_back(8'($urandom));
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.rx_byte      <= b;
      req_ch.end_of_frame <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_frame(input byte_q_t q, input frame_note_t note);
      frame_notes.push_back(note);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      // let the monitor log the last transfer before looking at the queue
      @(posedge clock);
      while (result_fifo.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_all_regs(input logic [7:0] hdr, input logic [7:0] ids [NUM_IDS]);
      for (int i = 0; i <= NUM_IDS; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.addr  <= csr_addr_type'(i);
         csr_ch.data  <= (csr_addr_type'(i) == REG_FRAME_HEADER) ? hdr : ids[i - 1];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.rx_byte      <= 8'h00;
      req_ch.end_of_frame <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.addr         <= REG_FRAME_HEADER;
      csr_ch.data         <= 8'h00;
      cfg_header = 8'h00;
      for (int i = 0; i < NUM_IDS; i++) cfg_ids[i] = 8'(i + 1);
      clear_frame_state();
      failed        = 1'b0;
      stall_cycles  = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold      = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : rsp_ready_drive
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : monitor
      cmd_result_t predicted;
      cmd_result_t got;
      frame_note_t note;
      bit          moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            if (predict_frame_byte(req_ch.rx_byte, req_ch.end_of_frame, predicted)) begin
               if (frame_notes.size() != 0) begin
                  note = frame_notes.pop_front();
                  if (note.typed) predicted = note.res;
               end
               result_fifo.push_back(predicted);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            moved = 1'b1;
            if (csr_ch.addr == REG_FRAME_HEADER) cfg_header = csr_ch.data;
            else cfg_ids[csr_ch.addr - 1] = csr_ch.data;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            got.status     = rsp_ch.status;
            got.command_id = rsp_ch.command_id;
            got.kind       = rsp_ch.command_kind;
            got.word       = {rsp_ch.word7, rsp_ch.word6, rsp_ch.word5, rsp_ch.word4,
                              rsp_ch.word3, rsp_ch.word2, rsp_ch.word1, rsp_ch.word0};
            if (result_fifo.size() == 0) begin
               $error("result transfer with no result pending");
               failed = 1'b1;
            end else begin
               check_result(got);
            end
         end
         if (moved) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      byte_q_t     q;
      byte_q_t     pay;
      frame_note_t note;
      int          sent;
      logic [7:0]  hdr_new;
      logic [7:0]  ids_new [NUM_IDS];

      @(posedge clock);
      while (reset) @(posedge clock);

      // directed frames under the reset configuration
      foreach (dir_rows[k]) begin
         pay = {};
         for (int i = 0; i < dir_rows[k].plen; i++) pay.push_back(dir_rows[k].fill + 8'(i));
         build_frame(q, dir_rows[k].hdr, dir_rows[k].id, pay, dir_rows[k].crc_flip);
         if (dir_rows[k].len != 0) q = q[0:dir_rows[k].len - 1];
         note.typed          = dir_rows[k].typed;
         note.res            = '0;
         note.res.status     = dir_rows[k].st;
         note.res.command_id = (dir_rows[k].len == 1) ? 8'h00 : dir_rows[k].id;
         note.res.kind       = dir_rows[k].kd;
         send_frame(q, note);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         case (ph)
            0: begin
               hdr_new = 8'hFF;
               ids_new = '{8'h00, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50};
            end
            1: begin
               // duplicate ids
               hdr_new = 8'h00;
               ids_new = '{8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h80, 8'h81, 8'h7F};
            end
            default: begin
               hdr_new = 8'($urandom);
               for (int i = 0; i < NUM_IDS; i++) begin
                  ids_new[i] = (i > 0 && $urandom_range(3) == 0) ? ids_new[i - 1]
                                                                 : 8'($urandom);
               end
            end
         endcase
         write_all_regs(hdr_new, ids_new);

         @(negedge clock);
         case (ph)
            1:       begin send_idle_pct = 87; rsp_stall_pct = 0;  end
            2, 5:    begin send_idle_pct = 0;  rsp_stall_pct = 87; end
            3:       begin send_idle_pct = 27; rsp_stall_pct = 27; end
            default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         // long receiver hold-off while bytes keep coming
         if (ph == 4) rsp_hold = HOLD_CYCLES;
         @(posedge clock);

         sent = 0;
         while (sent < PHASE_BYTES) begin
            make_random_frame(q, ph == 1 && sent == 0);
            note.typed = 1'b0;
            note.res   = '0;
            send_frame(q, note);
            sent += q.size();
         end
      end

      @(negedge clock);
      rsp_stall_pct = 0;
      @(posedge clock);
      wait_idle();
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[command_frame_checker_core.f]
sv/cfc_pkg.sv
sv/cfc_req_if.sv
sv/cfc_rsp_if.sv
sv/cfc_csr_if.sv
sv/cfc_csr_regs.sv
sv/cfc_frame_track.sv
sv/cfc_result.sv
sv/command_frame_checker_core.sv
test/tb_top.sv
